// ----- rtl/core/tpf_pkg.sv -----
package tpf_pkg;

	localparam int DEF_MAX_POINTS = 1024;
	localparam int DEF_FRAC_BITS  = 16;

	// Action codes carried by an input transaction.
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TIME = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_ACCEL       = 3'd0;
	localparam logic [2:0] REG_TOP_SPEED   = 3'd1;
	localparam logic [2:0] REG_PATH_LENGTH = 3'd2;
	localparam logic [2:0] REG_HOVER_MODE  = 3'd3;
	localparam logic [2:0] REG_POINT_COUNT = 3'd4;

	typedef struct packed {
		logic               action;
		logic        [9:0]  point_index;
		logic        [31:0] point_distance;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic        [31:0] time_now;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] speed_out;
		logic signed [31:0] distance_out;
	} result_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_TAKE,
		OP_SQ,
		OP_BRK_START,
		OP_BRK_CMP,
		OP_MUL_AD,
		OP_MUL_SD,
		OP_MUL_HALF,
		OP_UPD,
		OP_SRCH,
		OP_VDIFF,
		OP_VSQ,
		OP_VACC,
		OP_SQRT_START,
		OP_VMUL,
		OP_VDIV_START,
		OP_VSET,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic hover;
		logic div_done;
		logic sqrt_done;
		logic srch_done;
		logic sum_zero;
		logic k_last;
		logic out_free;
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SQ,
		S_BRK_DIV,
		S_BRK_WAIT,
		S_BRK_CMP,
		S_MUL_AD,
		S_MUL_SD,
		S_MUL_HALF,
		S_UPD,
		S_SRCH,
		S_VDIFF,
		S_VSQ,
		S_VACC,
		S_SQRT,
		S_SQRT_WAIT,
		S_VMUL,
		S_VDIV,
		S_VDIV_WAIT,
		S_VSET,
		S_OUT
	} state_t;

endpackage

// ----- rtl/core/tpf_item_if.sv -----
interface tpf_item_if import tpf_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/tpf_result_if.sv -----
interface tpf_result_if import tpf_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/tpf_div.sv -----
module tpf_div import tpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [33:0] divisor,
	output logic [63:0] quotient,
	output logic        done
);
	logic [63:0] quo_q;
	logic [34:0] rem_q;
	logic [33:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] rem_sh;
	logic        take;

	// One quotient bit per cycle, restoring form.
	assign rem_sh = {rem_q[33:0], quo_q[63]};
	assign take   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q <= {quo_q[62:0], take};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

// ----- rtl/core/tpf_sqrt.sv -----
module tpf_sqrt import tpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic [32:0] root,
	output logic        done
);
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;

	// Digit-by-digit floor square root, one result bit per cycle.
	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = r_q[32:0];
	assign done = done_q;
endmodule

// ----- rtl/core/tpf_ctrl.sv -----
module tpf_ctrl import tpf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_action,
	input  status_t status,
	output logic    item_ready,
	output cmd_t    cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid && item_action == ACT_TIME) begin
					state_d = status.hover ? S_OUT : S_SQ;
				end
			end
			S_SQ:        state_d = S_BRK_DIV;
			S_BRK_DIV:   state_d = S_BRK_WAIT;
			S_BRK_WAIT:  state_d = status.div_done ? S_BRK_CMP : S_BRK_WAIT;
			S_BRK_CMP:   state_d = S_MUL_AD;
			S_MUL_AD:    state_d = S_MUL_SD;
			S_MUL_SD:    state_d = S_MUL_HALF;
			S_MUL_HALF:  state_d = S_UPD;
			S_UPD:       state_d = S_SRCH;
			S_SRCH:      state_d = status.srch_done ? S_VDIFF : S_SRCH;
			S_VDIFF:     state_d = S_VSQ;
			S_VSQ:       state_d = S_VACC;
			S_VACC:      state_d = status.k_last ? S_SQRT : S_VSQ;
			S_SQRT:      state_d = status.sum_zero ? S_OUT : S_SQRT_WAIT;
			S_SQRT_WAIT: state_d = status.sqrt_done ? S_VMUL : S_SQRT_WAIT;
			S_VMUL:      state_d = S_VDIV;
			S_VDIV:      state_d = S_VDIV_WAIT;
			S_VDIV_WAIT: state_d = status.div_done ? S_VSET : S_VDIV_WAIT;
			S_VSET:      state_d = status.k_last ? S_OUT : S_VMUL;
			S_OUT:       state_d = status.out_free ? S_IDLE : S_OUT;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		cmd.op     = OP_NONE;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_action == ACT_LOAD) begin
						cmd.op = OP_LOAD;
					end else if (!status.hover) begin
						cmd.op = OP_TAKE;
					end
				end
			end
			S_SQ:       cmd.op = OP_SQ;
			S_BRK_DIV:  cmd.op = OP_BRK_START;
			S_BRK_CMP:  cmd.op = OP_BRK_CMP;
			S_MUL_AD:   cmd.op = OP_MUL_AD;
			S_MUL_SD:   cmd.op = OP_MUL_SD;
			S_MUL_HALF: cmd.op = OP_MUL_HALF;
			S_UPD:      cmd.op = OP_UPD;
			S_SRCH:     cmd.op = OP_SRCH;
			S_VDIFF:    cmd.op = OP_VDIFF;
			S_VSQ:      cmd.op = OP_VSQ;
			S_VACC:     cmd.op = OP_VACC;
			S_SQRT:     cmd.op = status.sum_zero ? OP_NONE : OP_SQRT_START;
			S_VMUL:     cmd.op = OP_VMUL;
			S_VDIV:     cmd.op = OP_VDIV_START;
			S_VSET:     cmd.op = OP_VSET;
			S_OUT:      cmd.op = status.out_free ? OP_EMIT : OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end
endmodule

// ----- rtl/core/tpf_dp.sv -----
module tpf_dp import tpf_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  item_t       item,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        result_ready,
	output logic        result_valid,
	output result_t     result,
	output status_t     status
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [16:0] MAXP = 17'(MAX_POINTS);
	localparam logic [40:0] QCLAMP = 41'h100_0000_0000;

	// Configuration.
	logic [31:0] accel_q, top_q, plen_q;
	logic        hover_q;
	logic [10:0] count_q;

	// Motion state.
	logic signed [31:0] trav_q, speed_q;
	logic        [31:0] last_q, t_q;
	logic signed [31:0] cur_q [3];
	logic signed [31:0] prev_q [3];
	logic signed [31:0] vel_q [3];

	// Working registers.
	logic        dt_neg_q;
	logic [31:0] dtm_q;
	logic        a_neg_q;
	logic [31:0] a_mag_q;
	logic [40:0] qad_p_q, qsd_p_q;
	logic        qad_neg_q;
	logic [63:0] mul_q;
	logic [30:0] m_q [3];
	logic        dneg_q [3];
	logic [1:0]  k_q;
	logic [63:0] sum_q;
	logic [32:0] norm_q;
	logic [CW-1:0] sidx_q;
	logic        rdv_q;
	logic [127:0] rd_q;
	logic        out_v_q;
	result_t     out_q;

	logic [127:0] mem [MAX_POINTS];

	// Helpers.
	logic [32:0]  dt_w, dt_mag;
	logic [32:0]  sp_mag33;
	logic [31:0]  sm;
	logic [63:0]  shifted;
	logic [40:0]  qp;
	logic         speed_neg;
	logic [31:0]  mul_a, mul_b;
	logic [16:0]  idx17, cnt17, n17;
	logic         idx_ok;
	logic [CW-1:0] n_pts;
	logic         issue, hit;
	logic [31:0]  xmag;
	logic [63:0]  div_quo;
	logic         div_start, div_done;
	logic [63:0]  div_dvd;
	logic [33:0]  div_dvs;
	logic [32:0]  sq_root;
	logic         sq_done;
	logic signed [65:0] brk_rhs, trav66;
	logic signed [43:0] dist44, speed44;
	logic signed [32:0] diff [3];
	logic [32:0]  dmag [3];
	logic         big;

	function automatic logic signed [43:0] sval(input logic [40:0] p, input logic neg);
		logic signed [43:0] v;
		v = $signed({3'b000, p});
		return neg ? -v : v;
	endfunction

	function automatic logic [31:0] sat44(input logic signed [43:0] v);
		logic [31:0] r;
		if (v > 44'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -44'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign speed_neg = speed_q[31];
	assign sp_mag33  = speed_neg ? -{speed_q[31], speed_q} : {speed_q[31], speed_q};
	assign sm        = sp_mag33[31:0];
	assign dt_w      = {1'b0, item.time_now} - {1'b0, last_q};
	assign dt_mag    = dt_w[32] ? -dt_w : dt_w;

	// Fixed-point product magnitude with the upper clamp.
	assign shifted = mul_q >> FRAC_BITS;
	assign qp      = (shifted > {23'd0, QCLAMP}) ? QCLAMP : shifted[40:0];

	// Magnitude of the saturated a*dt term.
	always_comb begin
		if (qad_neg_q) begin
			xmag = (qad_p_q > 41'h0_8000_0000) ? 32'h8000_0000 : qad_p_q[31:0];
		end else begin
			xmag = (qad_p_q > 41'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qad_p_q[31:0];
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ: begin
				mul_a = sm;
				mul_b = sm;
			end
			OP_MUL_AD: begin
				mul_a = a_mag_q;
				mul_b = dtm_q;
			end
			OP_MUL_SD: begin
				mul_a = sm;
				mul_b = dtm_q;
			end
			OP_MUL_HALF: begin
				mul_a = xmag;
				mul_b = dtm_q;
			end
			OP_VSQ: begin
				mul_a = {1'b0, m_q[k_q]};
				mul_b = {1'b0, m_q[k_q]};
			end
			OP_VMUL: begin
				mul_a = {1'b0, m_q[k_q]};
				mul_b = sm;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Table addressing.
	assign idx17  = 17'(item.point_index);
	assign idx_ok = idx17 < MAXP;
	assign cnt17  = 17'(count_q);
	assign n17    = (cnt17 > MAXP) ? MAXP : cnt17;
	assign n_pts  = n17[CW-1:0];
	assign issue  = sidx_q < n_pts;
	assign hit    = $signed({1'b0, rd_q[127:96]}) > $signed({trav_q[31], trav_q});

	// Braking test and state updates.
	assign trav66  = 66'(trav_q);
	assign brk_rhs = $signed({34'd0, plen_q}) - $signed({2'b00, div_quo});
	assign dist44  = 44'(trav_q) + sval(qsd_p_q, speed_neg ^ dt_neg_q)
		+ sval(qp >> 1, qad_neg_q ^ dt_neg_q);
	assign speed44 = 44'(speed_q) + sval(qad_p_q, qad_neg_q);

	always_comb begin
		big = 1'b0;
		for (int i = 0; i < 3; i++) begin
			diff[i] = 33'(cur_q[i]) - 33'(prev_q[i]);
			dmag[i] = diff[i][32] ? -diff[i] : diff[i];
			big     = big | dmag[i][31];
		end
	end

	assign div_start = (cmd.op == OP_BRK_START) || (cmd.op == OP_VDIV_START);
	assign div_dvd   = mul_q;
	assign div_dvs   = (cmd.op == OP_BRK_START) ? {1'b0, accel_q, 1'b0} : {1'b0, norm_q};

	tpf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.done     (div_done)
	);

	tpf_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_SQRT_START),
		.radicand (sum_q),
		.root     (sq_root),
		.done     (sq_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= 32'(1) << FRAC_BITS;
			top_q   <= 32'(10) << FRAC_BITS;
			plen_q  <= '0;
			hover_q <= 1'b0;
			count_q <= 11'd1024;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_ACCEL:       accel_q <= cfg_wdata;
				REG_TOP_SPEED:   top_q   <= cfg_wdata;
				REG_PATH_LENGTH: plen_q  <= cfg_wdata;
				REG_HOVER_MODE:  hover_q <= cfg_wdata[0];
				REG_POINT_COUNT: count_q <= cfg_wdata[10:0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trav_q  <= '0;
			speed_q <= '0;
			last_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				cur_q[i]  <= '0;
				prev_q[i] <= '0;
				vel_q[i]  <= '0;
			end
			out_v_q <= 1'b0;
			rdv_q   <= 1'b0;
			k_q     <= '0;
			sidx_q  <= '0;
		end else begin
			if (result_ready) begin
				out_v_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD: begin
					if (idx_ok && idx17 == 17'd0) begin
						cur_q[0] <= item.point_x;
						cur_q[1] <= item.point_y;
						cur_q[2] <= item.point_z;
					end
				end
				OP_UPD: begin
					trav_q  <= sat44(dist44);
					speed_q <= sat44(speed44);
					last_q  <= t_q;
					for (int i = 0; i < 3; i++) begin
						prev_q[i] <= cur_q[i];
					end
					sidx_q <= '0;
					rdv_q  <= 1'b0;
				end
				OP_SRCH: begin
					rdv_q <= issue;
					if (issue) begin
						sidx_q <= sidx_q + CW'(1);
					end
					if (rdv_q && hit) begin
						cur_q[0] <= rd_q[95:64];
						cur_q[1] <= rd_q[63:32];
						cur_q[2] <= rd_q[31:0];
					end
				end
				OP_VDIFF: k_q <= '0;
				OP_VACC:  k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				OP_VSET: begin
					if (dneg_q[k_q] ^ speed_neg) begin
						vel_q[k_q] <= (div_quo > 64'h8000_0000) ? 32'h8000_0000
							: -div_quo[31:0];
					end else begin
						vel_q[k_q] <= (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
							: div_quo[31:0];
					end
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				end
				OP_EMIT: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Payload and scratch registers.
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		case (cmd.op)
			OP_TAKE: begin
				t_q      <= item.time_now;
				dt_neg_q <= dt_w[32];
				dtm_q    <= dt_mag[31:0];
				a_neg_q  <= 1'b0;
				a_mag_q  <= ($signed({speed_q[31], speed_q}) < $signed({1'b0, top_q}))
					? accel_q : 32'd0;
			end
			OP_BRK_CMP: begin
				if (accel_q == 32'd0 || trav66 >= brk_rhs) begin
					a_neg_q <= 1'b1;
					a_mag_q <= accel_q;
				end
			end
			OP_MUL_SD: begin
				qad_p_q   <= qp;
				qad_neg_q <= a_neg_q ^ dt_neg_q;
			end
			OP_MUL_HALF: qsd_p_q <= qp;
			OP_VDIFF: begin
				sum_q <= '0;
				for (int i = 0; i < 3; i++) begin
					m_q[i]    <= big ? 31'(dmag[i] >> 2) : dmag[i][30:0];
					dneg_q[i] <= diff[i][32];
				end
			end
			OP_VACC: sum_q <= sum_q + mul_q;
			OP_EMIT: begin
				out_q.pos_x        <= cur_q[0];
				out_q.pos_y        <= cur_q[1];
				out_q.pos_z        <= cur_q[2];
				out_q.vel_x        <= vel_q[0];
				out_q.vel_y        <= vel_q[1];
				out_q.vel_z        <= vel_q[2];
				out_q.speed_out    <= speed_q;
				out_q.distance_out <= trav_q;
			end
			default: ;
		endcase
		if (sq_done) begin
			norm_q <= sq_root;
		end
	end

	// Path point table: distance, x, y, z in one word.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && idx_ok) begin
			mem[idx17[AW-1:0]] <= {item.point_distance, item.point_x,
				item.point_y, item.point_z};
		end
		if (cmd.op == OP_SRCH && issue) begin
			rd_q <= mem[sidx_q[AW-1:0]];
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	assign status.hover     = hover_q;
	assign status.div_done  = div_done;
	assign status.sqrt_done = sq_done;
	assign status.srch_done = (rdv_q && hit) || !issue;
	assign status.sum_zero  = sum_q == 64'd0;
	assign status.k_last    = k_q == 2'd2;
	assign status.out_free  = !out_v_q || result_ready;
endmodule

// ----- rtl/core/trapezoidal_path_follower.sv -----
// Load transactions each write one path point; they give no result.
// A time transaction drives a table scan over up to point_count points, the divider
// (run once for braking and once per axis) and the square root.
// One transaction is worked at a time; a finished result waits in an output register.
// Reset (arst_n low) clears motion state and resets settings; the point table is kept.
module trapezoidal_path_follower import tpf_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	tpf_item_if.sink     item,
	tpf_result_if.source result,
	input  logic         cfg_wen,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);
	cmd_t    cmd;
	status_t status;
	logic    ready;

	// Outside hover mode the controller sequences each time transaction: braking distance,
	// integration, the table scan and the velocity normalization, then hands the result over.
	tpf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_action (item.data.action),
		.status      (status),
		.item_ready  (ready),
		.cmd         (cmd)
	);

	// The datapath holds the table, the motion state, one shared multiplier,
	// the divider and the square root unit.
	tpf_dp #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item.data),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.result       (result.data),
		.status       (status)
	);

	assign item.ready = ready;
endmodule

// ----- tb/trapezoidal_path_follower_tb.sv -----
`timescale 1ns / 100ps

module trapezoidal_path_follower_tb;
	import tpf_pkg::*;

	localparam int NPTS = 1024;
	localparam longint CYCLE_LIMIT = 64'd3_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	tpf_item_if item_ch ();
	tpf_result_if result_ch ();

	trapezoidal_path_follower uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch.sink),
		.result(result_ch.source),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the block: path table, motion state and registers.
	logic [31:0] tbl_dist [NPTS];
	logic signed [31:0] tbl_x [NPTS];
	logic signed [31:0] tbl_y [NPTS];
	logic signed [31:0] tbl_z [NPTS];
	longint trav, spd, t_last;
	longint here [3];
	longint prev_pos [3];
	longint vel [3];
	longint r_accel, r_top, r_len, r_hover, r_count;

	result_t expected_q [$];
	int errors = 0;
	longint cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint absval(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Fixed-point product: magnitudes multiply, the sign is put back afterwards.
	function automatic longint fx_mul(longint a, longint b);
		logic [63:0] p;
		p = (64'(absval(a)) * 64'(absval(b))) >> 16;
		if (p > (64'd1 << 40)) p = 64'd1 << 40;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Points the velocity from the previous to the current position, scaled by speed.
	function automatic void steer();
		longint d [3];
		logic [63:0] m [3];
		logic [63:0] sum, norm, q;
		bit big;
		big = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = here[i] - prev_pos[i];
			m[i] = 64'(absval(d[i]));
			if (m[i] >= 64'h8000_0000) big = 1;
		end
		for (int i = 0; i < 3; i++) begin
			if (big) m[i] = m[i] >> 2;
			sum += m[i] * m[i];
		end
		if (sum == 0) return;
		norm = floor_sqrt(sum);
		if (norm == 0) return;
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 64'(absval(spd))) / norm;
			vel[i] = clamp32(((d[i] < 0) != (spd < 0)) ? -longint'(q) : longint'(q));
		end
	endfunction

	function automatic void move_to(longint t);
		longint dt, a, brk, dist_sum, half, n;
		logic [63:0] sm;
		dt = t - t_last;
		a = (spd < r_top) ? r_accel : 0;
		sm = 64'(absval(spd));
		if (r_accel == 0) brk = 64'sh7FFF_FFFF_FFFF_FFFF / 4;
		else brk = longint'((sm * sm) / (64'd2 * 64'(r_accel)));
		if (trav >= r_len - brk) a = -r_accel;
		half = fx_mul(clamp32(fx_mul(a, dt)), dt) / 2;
		dist_sum = trav + fx_mul(spd, dt) + half;
		trav = clamp32(dist_sum);
		spd = clamp32(spd + fx_mul(a, dt));
		t_last = t;
		prev_pos = here;
		n = r_count > NPTS ? NPTS : r_count;
		for (int i = 0; i < n; i++) begin
			if (longint'(tbl_dist[i]) > trav) begin
				here[0] = tbl_x[i];
				here[1] = tbl_y[i];
				here[2] = tbl_z[i];
				break;
			end
		end
		steer();
	endfunction

	function automatic void predict_motion(item_t it);
		result_t r;
		if (it.action == ACT_LOAD) begin
			tbl_dist[it.point_index] = it.point_distance;
			tbl_x[it.point_index] = it.point_x;
			tbl_y[it.point_index] = it.point_y;
			tbl_z[it.point_index] = it.point_z;
			if (it.point_index == 0) begin
				here[0] = it.point_x;
				here[1] = it.point_y;
				here[2] = it.point_z;
			end
			return;
		end
		if (r_hover == 0) move_to(longint'(it.time_now));
		r.pos_x = here[0][31:0];
		r.pos_y = here[1][31:0];
		r.pos_z = here[2][31:0];
		r.vel_x = vel[0][31:0];
		r.vel_y = vel[1][31:0];
		r.vel_z = vel[2][31:0];
		r.speed_out = spd[31:0];
		r.distance_out = trav[31:0];
		expected_q.push_back(r);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
	endtask

	// Drives one transaction and waits for it to be accepted. Valid stays high on
	// return; the next transaction replaces the data, and a drain or a register write takes it down.
	task automatic send_item(item_t it);
		while (($urandom % 100) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		predict_motion(it);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		item_ch.valid <= 1'b0;
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_ACCEL: r_accel = val;
			REG_TOP_SPEED: r_top = val;
			REG_PATH_LENGTH: r_len = val;
			REG_HOVER_MODE: r_hover = val[0];
			REG_POINT_COUNT: r_count = val[10:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Waits until every expected result has come back; loads need no extra wait.
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic item_t load_item(int idx, logic [31:0] d, logic [31:0] x,
			logic [31:0] y, logic [31:0] z);
		item_t it;
		it = '0;
		it.action = ACT_LOAD;
		it.point_index = idx[9:0];
		it.point_distance = d;
		it.point_x = x;
		it.point_y = y;
		it.point_z = z;
		it.time_now = $urandom;
		return it;
	endfunction

	function automatic item_t time_item(logic [31:0] t);
		item_t it;
		it = '0;
		it.action = ACT_TIME;
		it.point_index = $urandom;
		it.point_distance = $urandom;
		it.point_x = $urandom;
		it.point_y = $urandom;
		it.point_z = $urandom;
		it.time_now = t;
		return it;
	endfunction

	// Loads a fresh path of n points (rising distances unless wild) and sets point_count.
	task automatic load_path(int n, bit wild);
		logic [31:0] d;
		d = $urandom_range(0, 32'h0003_0000);
		for (int i = 0; i < n; i++) begin
			if (wild)
				send_item(load_item(i, $urandom, $urandom, $urandom, $urandom));
			else
				send_item(load_item(i, d, $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
					$urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
					$urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000));
			d = d + $urandom_range(1, 32'h0008_0000);
		end
		drain();
		write_reg(REG_POINT_COUNT, n);
	endtask

	// Extremes of every field and the named corner cases, with a short path.
	task automatic test_directed();
		write_reg(REG_POINT_COUNT, 4);
		send_item(load_item(0, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
		send_item(load_item(1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
		send_item(load_item(2, 32'h0010_0000, 32'h0, 32'h0, 32'h0));
		send_item(load_item(3, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
		send_item(load_item(1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		write_reg(REG_PATH_LENGTH, 32'h0010_0000);
		send_item(time_item(32'h0001_0000));    // accelerating, large displacement
		send_item(time_item(32'h0002_0000));
		send_item(time_item(32'h0002_0000));    // zero elapsed time
		send_item(time_item(32'h0000_8000));    // time going backwards
		send_item(time_item(32'h0004_0000));
		drain();
		write_reg(REG_HOVER_MODE, 1);
		send_item(time_item(32'hFFFF_FFFF));
		send_item(time_item(32'h0));
		drain();
		write_reg(REG_HOVER_MODE, 0);
		write_reg(REG_ACCEL, 32'h0);            // braking always active, no acceleration
		send_item(time_item(32'h0005_0000));
		drain();
		write_reg(REG_ACCEL, 32'hFFFF_FFFF);
		write_reg(REG_TOP_SPEED, 32'hFFFF_FFFF);
		send_item(time_item(32'h0006_0000));
		send_item(time_item(32'hFFFF_FFFF));    // saturating distance and speed
		drain();
		write_reg(REG_TOP_SPEED, 32'h0);
		write_reg(REG_POINT_COUNT, 0);          // nothing searched
		send_item(time_item(32'h0));
		drain();
	endtask

	// Well-formed paths with random timing, plus some wild points and settings.
	task automatic test_random_paths(int items);
		int sent;
		logic [31:0] t;
		sent = 0;
		while (sent < items) begin
			int n;
			bit wild;
			wild = ($urandom % 5) == 0;
			n = ($urandom % 12 == 0) ? $urandom_range(40, 120) : $urandom_range(2, 10);
			write_reg(REG_ACCEL, wild ? $urandom : $urandom_range(1, 32'h0004_0000));
			write_reg(REG_TOP_SPEED, wild ? $urandom : $urandom_range(0, 32'h0010_0000));
			write_reg(REG_PATH_LENGTH, wild ? $urandom : $urandom_range(0, 32'h0040_0000));
			write_reg(REG_HOVER_MODE, ($urandom % 8) == 0);
			load_path(n, wild);
			sent += n;
			t = $urandom_range(0, 32'h0004_0000);
			repeat ($urandom_range(4, 12)) begin
				if ($urandom % 10 == 0)
					send_item(load_item($urandom_range(1, n - 1), $urandom, $urandom,
						$urandom, $urandom));
				else if ($urandom % 15 == 0)
					send_item(time_item($urandom));
				else begin
					t = t + $urandom_range(0, 32'h0002_0000);
					send_item(time_item(t));
				end
				sent++;
			end
			drain();
		end
	endtask

	// Checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 32'h0, 32'h0);
			end else begin
				result_t e, g;
				e = expected_q.pop_front();
				g = result_ch.data;
				if (g.pos_x !== e.pos_x) report_mismatch("pos_x", g.pos_x, e.pos_x);
				if (g.pos_y !== e.pos_y) report_mismatch("pos_y", g.pos_y, e.pos_y);
				if (g.pos_z !== e.pos_z) report_mismatch("pos_z", g.pos_z, e.pos_z);
				if (g.vel_x !== e.vel_x) report_mismatch("vel_x", g.vel_x, e.vel_x);
				if (g.vel_y !== e.vel_y) report_mismatch("vel_y", g.vel_y, e.vel_y);
				if (g.vel_z !== e.vel_z) report_mismatch("vel_z", g.vel_z, e.vel_z);
				if (g.speed_out !== e.speed_out)
					report_mismatch("speed_out", g.speed_out, e.speed_out);
				if (g.distance_out !== e.distance_out)
					report_mismatch("distance_out", g.distance_out, e.distance_out);
			end
		end
	end

	// Receiver stalls at random, at the falling edge.
	always @(negedge clk) begin
		result_ch.ready <= ($urandom % 100) >= recv_idle_pct;
	end

	// Cycle counter that ends a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		trav = 0;
		spd = 0;
		t_last = 0;
		for (int i = 0; i < 3; i++) begin
			here[i] = 0;
			prev_pos[i] = 0;
			vel[i] = 0;
		end
		r_accel = 64'h1_0000;
		r_top = 64'hA_0000;
		r_len = 0;
		r_hover = 0;
		r_count = 1024;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 27;
		recv_idle_pct = 68;
		test_directed();
		test_random_paths(180);
		send_idle_pct = 68;
		recv_idle_pct = 27;
		test_random_paths(180);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_paths(180);

		drain();
		repeat (200) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
